FILE: hdl/bpq_pkg.sv
// Shared types and codes for the bounded priority queue.
// No dependencies; used by every module under hdl/ except bpq_ram.
package bpq_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request fields
    logic rd_top;    // read head entry, index := count-1
    logic shift;     // move read entry up one slot, read next one down
    logic put_next;  // write new pair above index, finish request
    logic put_zero;  // write new pair at slot 0, finish request
    logic res_imm;   // finish request with no storage access
    logic res_head;  // finish request with head entry read
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_enq;    // incoming operation is an enqueue
    logic in_head;   // incoming operation is a dequeue or peek
    logic full;
    logic empty;
    logic greater;   // read entry outranks the pending pair
    logic idx_zero;
  } sts_t;

endpackage

FILE: hdl/bounded_priority_queue_unit.sv
// Bounded priority queue of value/priority pairs, served highest priority
// first, newest first among equal priorities. Top level; depends on bpq_pkg,
// bpq_ctrl, bpq_dp (which holds bpq_ram).
//
// A request is taken when start is high and busy is low. Its result appears
// on status/head_value/head_priority/occupancy for exactly one cycle with
// done high; the receiver cannot stall it. Entries sit in one RAM sorted by
// ascending priority with the head at the top slot, so dequeue and peek need
// only one registered RAM read. An enqueue scans down from the head moving
// each higher-priority entry up one slot, one entry per cycle through the
// RAM's single read and write port, then writes the new pair; on an empty
// queue it writes slot 0 at once. Requests that touch no entry (full, empty,
// unused operation code) are not busy at all. done rises the cycle after the
// last busy cycle, or the cycle after the request for the non-busy cases.
module bounded_priority_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic        [bpq_pkg::OP_W-1:0]    operation,
  input  logic signed [bpq_pkg::DATA_W-1:0]  value,
  input  logic signed [bpq_pkg::DATA_W-1:0]  priority_req,
  output logic                               done,
  output logic        [bpq_pkg::ST_W-1:0]    status,
  output logic signed [bpq_pkg::DATA_W-1:0]  head_value,
  output logic signed [bpq_pkg::DATA_W-1:0]  head_priority,
  output logic        [bpq_pkg::OCC_W-1:0]   occupancy
);
  import bpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bpq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .sts  (sts)
  );

  bpq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .operation    (operation),
    .value        (value),
    .priority_req (priority_req),
    .done         (done),
    .status       (status),
    .head_value   (head_value),
    .head_priority(head_priority),
    .occupancy    (occupancy)
  );

endmodule

FILE: hdl/bpq_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module bpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  clk,
  we,
  waddr,
  wdata,
  re,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic             re;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bpq_ctrl.sv
// Request sequencer for the bounded priority queue.
// Depends on bpq_pkg; drives bpq_dp through cmd_t, watches sts_t.
module bpq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output bpq_pkg::cmd_t cmd,
  input  bpq_pkg::sts_t sts
);
  import bpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_INS  = 4'b0100,
    S_HEAD = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.in_enq && !sts.full) begin
            if (sts.empty) begin
              state_next = S_INS;
            end else begin
              cmd.rd_top = 1'b1;
              state_next = S_CMP;
            end
          end else if (sts.in_head && !sts.empty) begin
            cmd.rd_top = 1'b1;
            state_next = S_HEAD;
          end else begin
            cmd.res_imm = 1'b1;
          end
        end
      end
      S_CMP: begin
        if (sts.greater) begin
          cmd.shift = 1'b1;
          if (sts.idx_zero) begin
            state_next = S_INS;
          end
        end else begin
          cmd.put_next = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_INS: begin
        cmd.put_zero = 1'b1;
        state_next   = S_IDLE;
      end
      S_HEAD: begin
        cmd.res_head = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/bpq_dp.sv
// Datapath: entry storage (ascending priority, head at slot count-1),
// count, scan index, request and result registers. Depends on bpq_pkg, bpq_ram.
module bpq_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bpq_pkg::cmd_t                       cmd,
  output bpq_pkg::sts_t                       sts,
  input  logic        [bpq_pkg::OP_W-1:0]     operation,
  input  logic signed [bpq_pkg::DATA_W-1:0]   value,
  input  logic signed [bpq_pkg::DATA_W-1:0]   priority_req,
  output logic                                done,
  output logic        [bpq_pkg::ST_W-1:0]     status,
  output logic signed [bpq_pkg::DATA_W-1:0]   head_value,
  output logic signed [bpq_pkg::DATA_W-1:0]   head_priority,
  output logic        [bpq_pkg::OCC_W-1:0]    occupancy
);
  import bpq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = 2 * DATA_W;

  logic        [OP_W-1:0]   req_op;
  logic signed [DATA_W-1:0] req_value;
  logic signed [DATA_W-1:0] req_prio;
  logic        [AW-1:0]     idx;
  logic        [CW-1:0]     count, count_next;
  logic        [AW-1:0]     top_addr;
  logic        [ST_W-1:0]   imm_status;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  bpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign top_addr = AW'(count - CW'(1));

  always_comb begin
    sts.in_enq   = (operation == OP_ENQUEUE);
    sts.in_head  = operation inside {OP_DEQUEUE, OP_PEEK};
    sts.full     = (count == CW'(CAPACITY));
    sts.empty    = (count == '0);
    sts.greater  = $signed(ram_rdata[EW-1:DATA_W]) > req_prio;
    sts.idx_zero = (idx == '0);
  end

  always_comb begin
    if (sts.in_enq && sts.full) begin
      imm_status = ST_FULL;
    end else if (sts.in_head && sts.empty) begin
      imm_status = ST_EMPTY;
    end else begin
      imm_status = ST_OK;
    end
  end

  // storage port control
  always_comb begin
    ram_we    = cmd.shift || cmd.put_next || cmd.put_zero;
    ram_waddr = cmd.put_zero ? '0 : AW'(idx + AW'(1));
    ram_wdata = cmd.shift ? ram_rdata : {req_prio, req_value};
    ram_re    = cmd.rd_top || (cmd.shift && !sts.idx_zero);
    ram_raddr = cmd.rd_top ? top_addr : AW'(idx - AW'(1));
  end

  always_comb begin
    count_next = count;
    if (cmd.put_next || cmd.put_zero) begin
      count_next = count + CW'(1);
    end else if (cmd.res_head && (req_op == OP_DEQUEUE)) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.res_imm || cmd.put_next || cmd.put_zero || cmd.res_head;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= operation;
      req_value <= value;
      req_prio  <= priority_req;
    end
    if (cmd.rd_top) begin
      idx <= top_addr;
    end else if (cmd.shift && !sts.idx_zero) begin
      idx <= AW'(idx - AW'(1));
    end
    status    <= cmd.res_imm ? imm_status : ST_OK;
    occupancy <= OCC_W'(count_next);
    if (cmd.res_head) begin
      head_value    <= ram_rdata[DATA_W-1:0];
      head_priority <= ram_rdata[EW-1:DATA_W];
    end else begin
      head_value    <= '0;
      head_priority <= '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_occ_match: assert property (@(posedge clk) disable iff (rst)
    done |-> occupancy == OCC_W'(count))
    else $error("reported occupancy differs from held count");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> count != '0)
    else $error("shift with no entries held");

  a_full_report: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> count == CW'(CAPACITY))
    else $error("full reported below capacity");

endmodule

FILE: dv/bounded_priority_queue_unit_tb.sv
// Self-checking testbench for bounded_priority_queue_unit: directed corner cases,
// then random enqueue/dequeue/peek/unused-code traffic in three idle phases.
// Depends on bpq_pkg and the RTL under hdl/.
module bounded_priority_queue_unit_tb;
  import bpq_pkg::*;

  localparam int CAPACITY = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
  localparam int PHASE_ITEMS = 370;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic                     drain;     // hold off until all results are back
    int                       idle_pct;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] pri;
  } request_t;

  typedef struct {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] head_priority;
    logic [OCC_W-1:0]         occupancy;
  } result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [OP_W-1:0]          operation = OP_ENQUEUE;
  logic signed [DATA_W-1:0] value = '0;
  logic signed [DATA_W-1:0] priority_req = '0;
  logic                     busy;
  logic                     done;
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] head_value;
  logic signed [DATA_W-1:0] head_priority;
  logic [OCC_W-1:0]         occupancy;

  bounded_priority_queue_unit #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .value(value),
    .priority_req(priority_req),
    .done(done),
    .status(status),
    .head_value(head_value),
    .head_priority(head_priority),
    .occupancy(occupancy)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the queue, sorted by descending priority, head at index 0
  logic signed [DATA_W-1:0] shadow_val [CAPACITY];
  logic signed [DATA_W-1:0] shadow_pri [CAPACITY];
  int                       shadow_count = 0;

  request_t request_q[$];
  result_t  expected_results[$];
  int       sender_idle_pct = 13;
  logic     holding = 1'b0;
  logic     req_taken = 1'b0;
  int       mismatch_count = 0;
  int       results_seen = 0;
  int       cycle_count = 0;

  function automatic result_t apply_request(logic [OP_W-1:0] op,
                                            logic signed [DATA_W-1:0] val,
                                            logic signed [DATA_W-1:0] pri);
    result_t r;
    int pos;
    int i;
    r.status = ST_OK;
    r.head_value = '0;
    r.head_priority = '0;
    case (op)
      OP_ENQUEUE: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // new pair goes ahead of the first entry with priority <= its own
          pos = 0;
          while (pos < shadow_count && shadow_pri[pos] > pri) pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_val[i] = shadow_val[i-1];
            shadow_pri[i] = shadow_pri[i-1];
          end
          shadow_val[pos] = val;
          shadow_pri[pos] = pri;
          shadow_count++;
        end
      end
      OP_DEQUEUE, OP_PEEK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_value = shadow_val[0];
          r.head_priority = shadow_pri[0];
          if (op == OP_DEQUEUE) begin
            for (i = 1; i < shadow_count; i++) begin
              shadow_val[i-1] = shadow_val[i];
              shadow_pri[i-1] = shadow_pri[i];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR cycle %0d result %0d: %s got %0d expected %0d",
             cycle_count, results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
                             logic signed [DATA_W-1:0] pri);
    request_t t;
    t.drain = 1'b0;
    t.idle_pct = sender_idle_pct;
    t.op = op;
    t.val = val;
    t.pri = pri;
    request_q.push_back(t);
  endtask

  task automatic add_drain();
    request_t t;
    t.drain = 1'b1;
    t.idle_pct = 0;
    t.op = OP_ENQUEUE;
    t.val = '0;
    t.pri = '0;
    request_q.push_back(t);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_priority();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return $urandom_range(7) - 3;   // narrow range, lots of ties
    if (sel < 50) begin
      case ($urandom_range(3))
        0: return S32_MIN;
        1: return S32_MAX;
        2: return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  // alternating fill-biased and drain-biased runs so the queue hits both full and empty
  task automatic add_random_phase(int n);
    int left;
    int run;
    int sel;
    bit filling;
    logic [OP_W-1:0] op;
    left = n;
    filling = 1'b1;
    while (left > 0) begin
      run = $urandom_range(40, 10);
      if (run > left) run = left;
      repeat (run) begin
        sel = $urandom_range(99);
        if (sel < 2) op = OP_UNUSED;
        else if (filling) op = (sel < 72) ? OP_ENQUEUE : (sel < 90) ? OP_DEQUEUE : OP_PEEK;
        else op = (sel < 17) ? OP_ENQUEUE : (sel < 85) ? OP_DEQUEUE : OP_PEEK;
        add_request(op, $urandom, pick_priority());
      end
      left -= run;
      filling = !filling;
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // driver: one request held on the inputs until it is taken
  always @(negedge clk) begin : driver
    request_t nxt;
    if (!rst) begin
      if (req_taken) begin
        req_taken = 1'b0;
        holding = 1'b0;
      end
      if (!holding) begin
        while (request_q.size() > 0 && request_q[0].drain && expected_results.size() == 0)
          void'(request_q.pop_front());
        if (request_q.size() > 0 && !request_q[0].drain &&
            $urandom_range(99) >= request_q[0].idle_pct) begin
          nxt = request_q.pop_front();
          operation <= nxt.op;
          value <= nxt.val;
          priority_req <= nxt.pri;
          holding = 1'b1;
        end
      end
      start <= holding;
    end
  end

  // monitor: check the result strobe, then predict any request taken this edge
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (done) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding, status", status, 0);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (head_value !== want.head_value)
            report_mismatch("head_value", head_value, want.head_value);
          if (head_priority !== want.head_priority)
            report_mismatch("head_priority", head_priority, want.head_priority);
          if (occupancy !== want.occupancy)
            report_mismatch("occupancy", occupancy, want.occupancy);
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_request(operation, value, priority_req));
        req_taken = 1'b1;
      end
    end
  end

  initial begin
    int i;
    // directed: empty cases, extremes, tie ordering, fill to full
    sender_idle_pct = 13;
    add_request(OP_PEEK, 32'sd5, 32'sd9);
    add_request(OP_DEQUEUE, S32_MAX, S32_MIN);
    add_request(OP_UNUSED, -32'sd1, -32'sd1);
    add_request(OP_ENQUEUE, S32_MIN, S32_MAX);
    add_request(OP_ENQUEUE, S32_MAX, S32_MIN);
    add_request(OP_ENQUEUE, 32'sd1, 32'sd0);
    add_request(OP_ENQUEUE, 32'sd2, 32'sd0);
    add_request(OP_PEEK, -32'sd1, S32_MAX);
    add_request(OP_DEQUEUE, 32'sd0, 32'sd0);
    add_request(OP_DEQUEUE, 32'sd0, 32'sd0);
    for (i = 0; i < CAPACITY - 2; i++)
      add_request(OP_ENQUEUE, -32'sd100 - i, (i % 4) - 2);
    add_request(OP_ENQUEUE, 32'sd77, S32_MAX);
    add_request(OP_UNUSED, S32_MIN, S32_MAX);
    add_request(OP_PEEK, 32'sd0, 32'sd0);
    add_drain();

    add_random_phase(PHASE_ITEMS);
    add_drain();
    sender_idle_pct = 71;
    add_random_phase(PHASE_ITEMS);
    add_drain();
    sender_idle_pct = 0;
    add_random_phase(PHASE_ITEMS);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    do @(negedge clk);
    while (request_q.size() != 0 || holding || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: bounded_priority_queue_unit.f
hdl/bpq_pkg.sv
hdl/bpq_ram.sv
hdl/bpq_ctrl.sv
hdl/bpq_dp.sv
hdl/bounded_priority_queue_unit.sv
dv/bounded_priority_queue_unit_tb.sv
